>>> rtl/core/rmq_pkg.sv
// rmq_pkg: shared constants, types and command/status structs for the range minimum query block
// no dependencies
package rmq_pkg;

	localparam int unsigned MaxElements = 1024;
	localparam int unsigned PosW = 10;
	localparam int unsigned CountW = 11;
	localparam int unsigned ValW = 32;
	localparam int unsigned Levels = 11;
	localparam int unsigned LevW = 4;
	localparam int unsigned TabDepth = MaxElements * Levels;
	localparam int unsigned TabAddrW = 14;
	localparam logic [CountW-1:0] CountReset = 11'd1024;

	localparam logic KindLoad = 1'b0;
	localparam logic KindQuery = 1'b1;
	localparam logic StatusOk = 1'b0;
	localparam logic StatusRangeErr = 1'b1;

	// datapath commands from the controller
	typedef struct packed {
		logic load_wr;          // write value store at input position
		logic bld_init;         // start a table rebuild
		logic bld_step;         // advance the rebuild one step
		logic qry_start;        // latch query and issue first reads
		logic qry_step;         // advance query one step
		logic err_out;          // load a range-error result
		logic out_take;         // output item consumed
	} rmq_cmd_t;

	// datapath status for the controller
	typedef struct packed {
		logic bld_done;
		logic qry_done;
		logic out_full;
	} rmq_sts_t;

	// table address of (position, level)
	function automatic logic [TabAddrW-1:0] tab_addr(input logic [PosW-1:0] pos,
		input logic [LevW-1:0] lev);
		logic [TabAddrW+LevW-1:0] a;
		a = (TabAddrW+LevW)'(pos * Levels + lev);
		return a[TabAddrW-1:0];
	endfunction

endpackage

>>> rtl/core/rmq_ctrl.sv
// rmq_ctrl: controller state machine for the range minimum query block
// depends on rmq_pkg
module rmq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	output logic                   ready,
	input  logic                   kind,
	input  logic                   range_err,
	input  logic                   cfg_wr,
	input  rmq_pkg::rmq_sts_t      sts,
	input  logic                   out_ready,
	output rmq_pkg::rmq_cmd_t      cmd
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StBuild = 2'd1;
	localparam logic [1:0] StQuery = 2'd2;

	logic [1:0] state_q;
	logic       tab_valid_q;
	logic       acc;

	// accept only when idle and output register free or draining
	assign ready = (state_q == StIdle) && (!sts.out_full || out_ready);
	assign acc = valid && ready;

	always_comb begin
		cmd = '0;
		cmd.out_take = sts.out_full && out_ready;
		unique case (state_q)
			StIdle: begin
				if (acc) begin
					if (kind == rmq_pkg::KindLoad) begin
						cmd.load_wr = 1'b1;
					end else if (range_err) begin
						cmd.err_out = 1'b1;
					end else if (!tab_valid_q) begin
						cmd.bld_init = 1'b1;
					end else begin
						cmd.qry_start = 1'b1;
					end
				end
			end
			StBuild: begin
				if (sts.bld_done) begin
					cmd.qry_start = 1'b1;
				end else begin
					cmd.bld_step = 1'b1;
				end
			end
			StQuery: begin
				cmd.qry_step = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (cmd.bld_init) begin
						state_q <= StBuild;
					end else if (cmd.qry_start) begin
						state_q <= StQuery;
					end
				end
				StBuild: begin
					if (sts.bld_done) begin
						state_q <= StQuery;
					end
				end
				StQuery: begin
					if (sts.qry_done) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// table valid: a count write or an in-range load makes it stale, a finished rebuild sets it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_valid_q <= 1'b0;
		end else if (cfg_wr || (cmd.load_wr && !range_err)) begin
			tab_valid_q <= 1'b0;
		end else if (state_q == StBuild && sts.bld_done) begin
			tab_valid_q <= 1'b1;
		end
	end

endmodule

>>> rtl/core/rmq_dp.sv
// rmq_dp: value store, sparse table memory, rebuild and query sequencing, output register
// depends on rmq_pkg
module rmq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rmq_pkg::rmq_cmd_t                 cmd,
	output rmq_pkg::rmq_sts_t                 sts,
	input  logic [rmq_pkg::CountW-1:0]        count,
	input  logic                              kind,
	input  logic [rmq_pkg::PosW-1:0]          load_position,
	input  logic signed [rmq_pkg::ValW-1:0]   load_value,
	input  logic [rmq_pkg::PosW-1:0]          left_position,
	input  logic [rmq_pkg::PosW-1:0]          right_position,
	output logic                              range_err,
	output logic                              out_valid,
	output logic [rmq_pkg::PosW-1:0]          min_position,
	output logic signed [rmq_pkg::ValW-1:0]   min_value,
	output logic                              status
);

	localparam int unsigned PW = rmq_pkg::PosW;
	localparam int unsigned CW = rmq_pkg::CountW;
	localparam int unsigned VW = rmq_pkg::ValW;
	localparam int unsigned LW = rmq_pkg::LevW;
	localparam int unsigned AW = rmq_pkg::TabAddrW;

	// memories
	logic signed [VW-1:0] vmem [rmq_pkg::MaxElements];
	logic [PW-1:0]        tmem [rmq_pkg::TabDepth];

	logic [CW-1:0] n_eff;
	assign n_eff = (count > CW'(rmq_pkg::MaxElements)) ? CW'(rmq_pkg::MaxElements) : count;

	// range check: load position or query range against count
	logic [CW-1:0] chk_pos;
	always_comb begin
		if (kind == rmq_pkg::KindLoad) begin
			chk_pos = {1'b0, load_position};
		end else begin
			chk_pos = {1'b0, right_position};
		end
	end
	assign range_err = (chk_pos >= n_eff) ||
		((kind == rmq_pkg::KindQuery) && (left_position > right_position));

	// value store write
	always_ff @(posedge clk) begin
		if (cmd.load_wr && ({1'b0, load_position} < n_eff)) begin
			vmem[load_position] <= load_value;
		end
	end

	// rebuild sequencer: per entry read two candidates (two table reads, two value reads)
	// phase 0 issue table reads, 1 issue value reads, 2 compare and write
	logic [LW-1:0] lev_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    ph_q;
	logic          bld_on_q;
	// query sequencer
	logic [PW-1:0] ql_q, qr_q, qs_q, best_q;
	logic [LW-1:0] qk_q;
	logic [1:0]    qph_q;
	logic          qlast_q;

	// shared read ports
	logic [AW-1:0] ta_a, ta_b;
	logic [PW-1:0] td_a_q, td_b_q;
	logic [PW-1:0] va_a, va_b;
	logic signed [VW-1:0] vd_a_q, vd_b_q;
	logic [PW-1:0] ca_q, cb_q;

	logic [CW:0] span;
	logic [CW:0] half;
	assign span = (CW+1)'(1) << lev_q;
	assign half = span >> 1;

	logic [CW:0] qspan;
	assign qspan = (CW+1)'(1) << qk_q;

	// level for query length
	logic [CW-1:0] len;
	logic [LW-1:0] klog;
	assign len = CW'(right_position) - CW'(left_position) + CW'(1);
	always_comb begin
		klog = '0;
		for (int b = 1; b < rmq_pkg::Levels; b++) begin
			if (len[b]) begin
				klog = LW'(b);
			end
		end
	end

	logic [PW-1:0] best_mux;
	logic          b_less;
	assign b_less = vd_b_q < vd_a_q;
	assign best_mux = b_less ? cb_q : ca_q;

	// next query candidate start
	logic [CW:0] nxt_start;
	logic [CW:0] tail_start;
	assign nxt_start = (CW+1)'(qs_q) + qspan;
	assign tail_start = (CW+1)'(qr_q) + (CW+1)'(1) - qspan;

	// table read addresses
	always_comb begin
		if (bld_on_q) begin
			ta_a = rmq_pkg::tab_addr(idx_q[PW-1:0], lev_q - LW'(1));
			ta_b = rmq_pkg::tab_addr(PW'(idx_q + half[CW-1:0]), lev_q - LW'(1));
		end else begin
			ta_a = rmq_pkg::tab_addr(qs_q, qk_q);
			ta_b = ta_a;
		end
	end

	// value read addresses
	always_comb begin
		if (bld_on_q) begin
			va_a = td_a_q;
		end else begin
			va_a = best_q;
		end
		va_b = td_b_q;
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		td_a_q <= tmem[ta_a];
		td_b_q <= tmem[ta_b];
		vd_a_q <= vmem[va_a];
		vd_b_q <= vmem[va_b];
		ca_q <= va_a;
		cb_q <= va_b;
	end

	// table writes: level 0 identity, higher levels from compare
	logic          tw_en;
	logic [AW-1:0] tw_addr;
	logic [PW-1:0] tw_data;
	always_comb begin
		tw_en = 1'b0;
		tw_addr = rmq_pkg::tab_addr(idx_q[PW-1:0], lev_q);
		tw_data = idx_q[PW-1:0];
		if (bld_on_q && cmd.bld_step) begin
			if (lev_q == '0) begin
				tw_en = 1'b1;
			end else if (ph_q == 2'd2) begin
				tw_en = 1'b1;
				tw_data = best_mux;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tw_en) begin
			tmem[tw_addr] <= tw_data;
		end
	end

	// rebuild ends when next level span exceeds count or levels run out
	logic lvl_last;
	assign lvl_last = (lev_q == LW'(rmq_pkg::Levels - 1)) || ((span << 1) > (CW+1)'(n_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_on_q <= 1'b0;
			lev_q <= '0;
			idx_q <= '0;
			ph_q <= '0;
		end else if (cmd.bld_init) begin
			bld_on_q <= 1'b1;
			lev_q <= '0;
			idx_q <= '0;
			ph_q <= '0;
		end else if (cmd.qry_start) begin
			bld_on_q <= 1'b0;
		end else if (cmd.bld_step) begin
			if (lev_q == '0) begin
				if (idx_q + CW'(1) >= n_eff) begin
					idx_q <= '0;
					lev_q <= (n_eff < CW'(2)) ? '1 : LW'(1);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end else if (ph_q == 2'd2) begin
				ph_q <= '0;
				if ((CW+1)'(idx_q) + span >= (CW+1)'(n_eff)) begin
					idx_q <= '0;
					lev_q <= lvl_last ? '1 : lev_q + LW'(1);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	// query: best_q holds current winner position; each candidate takes
	// phase 0 table read, 1 value reads, 2 compare
	logic out_full_q;
	assign sts = '{
		bld_done: bld_on_q && (lev_q == '1),
		qry_done: cmd.qry_step && qph_q == 2'd2 && qlast_q,
		out_full: out_full_q
	};
	assign out_valid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qph_q <= '0;
			qlast_q <= 1'b0;
		end else if (cmd.qry_start) begin
			qph_q <= '0;
			qlast_q <= 1'b0;
		end else if (cmd.qry_step) begin
			qph_q <= (qph_q == 2'd2) ? 2'd0 : qph_q + 2'd1;
			if (qph_q == 2'd2) begin
				qlast_q <= 1'b0;
			end
			if (qph_q == 2'd0) begin
				qlast_q <= !((CW+1)'(qs_q) + qspan - (CW+1)'(1) < (CW+1)'(qr_q));
			end
		end
	end

	// query registers; left/right held from accept (ports stay stable only at accept)
	logic qfirst_q;
	always_ff @(posedge clk) begin
		if (cmd.bld_init || (cmd.qry_start && !bld_on_q)) begin
			ql_q <= left_position;
			qr_q <= right_position;
			qk_q <= klog;
		end
		if (cmd.qry_start) begin
			qs_q <= bld_on_q ? ql_q : left_position;
			qfirst_q <= 1'b1;
		end else if (cmd.qry_step) begin
			if (qph_q == 2'd1 && qfirst_q) begin
				best_q <= td_a_q;
			end
			if (qph_q == 2'd2) begin
				if (!qfirst_q) begin
					best_q <= b_less ? cb_q : ca_q;
				end
				qfirst_q <= 1'b0;
				if (nxt_start + qspan - (CW+1)'(1) < (CW+1)'(qr_q)) begin
					qs_q <= nxt_start[PW-1:0];
				end else begin
					qs_q <= tail_start[PW-1:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.err_out || sts.qry_done) begin
			out_full_q <= 1'b1;
		end else if (cmd.out_take) begin
			out_full_q <= 1'b0;
		end
	end

	// first candidate arrives on the b read port, later ones compete with best_q on port a
	logic [PW-1:0] fin_pos;
	logic signed [VW-1:0] fin_val;
	assign fin_pos = qfirst_q ? cb_q : (b_less ? cb_q : ca_q);
	assign fin_val = qfirst_q ? vd_b_q : (b_less ? vd_b_q : vd_a_q);

	always_ff @(posedge clk) begin
		if (cmd.err_out) begin
			min_position <= '0;
			min_value <= '0;
			status <= rmq_pkg::StatusRangeErr;
		end else if (sts.qry_done) begin
			min_position <= fin_pos;
			min_value <= fin_val;
			status <= rmq_pkg::StatusOk;
		end
	end

endmodule

>>> rtl/core/rmq_regs.sv
// rmq_regs: APB-style configuration register for the element count
// depends on rmq_pkg
module rmq_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [1:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic                        cfg_wr,
	output logic [rmq_pkg::CountW-1:0]  count
);

	localparam logic [1:0] AddrCount = 2'd0;

	logic [rmq_pkg::CountW-1:0] count_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == AddrCount);
	assign count = count_q;
	assign prdata = (paddr == AddrCount) ? {21'd0, count_q} : 32'd0;

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rmq_pkg::CountReset;
		end else if (cfg_wr) begin
			count_q <= pwdata[rmq_pkg::CountW-1:0];
		end
	end

endmodule

>>> rtl/core/range_minimum_index_query.sv
// Range minimum index query over up to 1024 signed 32-bit values held in an internal
// memory. A load item writes the value store, and a query with a range error has a
// range-error result registered into the output register. A query item returns the leftmost
// minimum position and its value; with a valid sparse table it reads one table candidate
// when the range length is a power of two and two otherwise, each through table read, value
// read and compare. After an in-range load or a count write the next query first rebuilds
// the table: level 0 first, then each entry on each higher level through the same steps.
// A result waiting on out_ready blocks input.
module range_minimum_index_query (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                ready,
	input  logic                kind,
	input  logic [9:0]          load_position,
	input  logic signed [31:0]  load_value,
	input  logic [9:0]          left_position,
	input  logic [9:0]          right_position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [9:0]          min_position,
	output logic signed [31:0]  min_value,
	output logic                status,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	rmq_pkg::rmq_cmd_t cmd;
	rmq_pkg::rmq_sts_t sts;
	logic cfg_wr;
	logic range_err;
	logic [rmq_pkg::CountW-1:0] count;

	rmq_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg_wr, .count
	);

	rmq_ctrl u_ctrl (
		.clk, .arst_n, .valid, .ready, .kind, .range_err, .cfg_wr, .sts, .out_ready, .cmd
	);

	rmq_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .count, .kind, .load_position, .load_value,
		.left_position, .right_position, .range_err, .out_valid,
		.min_position, .min_value, .status
	);

endmodule

>>> rtl/core/rmq_checker.sv
// rmq_checker: port-level assertions for range_minimum_index_query
// bound to the top level below
module rmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  min_position,
	input logic [31:0] min_value,
	input logic        status,
	input logic        pready
);

	// a range error carries zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> min_position == '0 && min_value == '0)
		else $error("range error with nonzero payload");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_position))
		else $error("output item dropped while stalled");

	// no item accepted while a result is stalled
	a_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !ready)
		else $error("accept while output blocked");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind range_minimum_index_query rmq_checker u_rmq_checker (.*);
